[rtl/core/mtxq_pkg.sv]
// mtxq_pkg: shared types and codes of the midi transmit event queue
// no dependencies; imported by the top level, its checker and the bench
package mtxq_pkg;

    // input command codes
    localparam logic [2:0] CMD_NOTE_ON  = 3'd0;
    localparam logic [2:0] CMD_NOTE_OFF = 3'd1;
    localparam logic [2:0] CMD_CC       = 3'd2;
    localparam logic [2:0] CMD_USB_CC   = 3'd3;
    localparam logic [2:0] CMD_PROGRAM  = 3'd4;
    localparam logic [2:0] CMD_BEND     = 3'd5;
    localparam logic [2:0] CMD_DISCARD  = 3'd6;
    localparam logic [2:0] CMD_SERVICE  = 3'd7;

    // result kinds
    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_USB  = 2'd1;
    localparam logic [1:0] KIND_UART = 2'd2;

    // status byte high nibbles
    localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
    localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
    localparam logic [7:0] STATUS_CC       = 8'hb0;
    localparam logic [7:0] STATUS_PROGRAM  = 8'hc0;
    localparam logic [7:0] STATUS_BEND     = 8'he0;

    localparam logic [15:0] BEND_MAX  = 16'd16383;
    localparam logic [6:0]  LEVEL_MAX = 7'd127;

    // one queued event
    typedef struct packed {
        logic [7:0] status;
        logic [6:0] d1;
        logic [6:0] d2;
        logic       three_bytes;
        logic       usb_only;
        logic       usb_done;
        logic [1:0] pos;
    } t_entry;

    // one result word
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] usb_packet;
        logic [7:0]  uart_byte;
        logic        accepted;
        logic [6:0]  queue_level;
        logic        last;
    } t_result;

endpackage

[rtl/core/mtxq_if.sv]
// mtxq_in_if / mtxq_out_if: valid/ready channels of the midi transmit event queue
// no dependencies
interface mtxq_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [3:0]  channel;
    logic [7:0]  data1;
    logic [7:0]  data2;
    logic [15:0] bend;
    logic        usb_mounted;
    logic        usb_ready;
    logic        uart_writable;

    modport source (
        output valid, cmd, channel, data1, data2, bend, usb_mounted, usb_ready, uart_writable,
        input  ready
    );
    modport sink (
        input  valid, cmd, channel, data1, data2, bend, usb_mounted, usb_ready, uart_writable,
        output ready
    );
endinterface

interface mtxq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] usb_packet;
    logic [7:0]  uart_byte;
    logic        accepted;
    logic [6:0]  queue_level;
    logic        last;

    modport source (
        output valid, kind, usb_packet, uart_byte, accepted, queue_level, last,
        input  ready
    );
    modport sink (
        input  valid, kind, usb_packet, uart_byte, accepted, queue_level, last,
        output ready
    );
endinterface

[rtl/core/midi_tx_event_queue.sv]
// midi_tx_event_queue: ring queue of midi channel messages feeding usb and uart sinks
// depends on mtxq_pkg and the channel interfaces in mtxq_if.sv
//
// usage: i_in carries one command word per handshake (message build, discard or
// service); o_out returns one or two result words per command, the final one
// flagged by last. message commands write one entry of the event memory at the
// write pointer; a full queue drops the message and reports accepted low.
// discard moves the read pointer onto the write pointer.
// handshakes: message, discard and empty-queue service words give their result
// in the cycle after acceptance and, while the output is free, can follow each
// other every cycle. a service word on a non-empty queue reads the head entry
// through the registered memory read, then modifies and writes it back once the
// output register is free; a second result word follows when it sends both a
// usb packet and a uart byte. no new word is accepted until the write-back is
// done, so no two accesses to one entry overlap.
// stall: results sit in an output register; input is taken only while that
// register is free or being emptied in the same cycle.
// reset: pointers, state and output valid are cleared; the event memory is not
// cleared, since only entries between the pointers are ever read.
module midi_tx_event_queue #(
    parameter int QUEUE_DEPTH = 128
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mtxq_in_if.sink         i_in,
    mtxq_out_if.source      o_out
);
    import mtxq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W + 1)'(QUEUE_DEPTH);
    localparam logic [PTR_W:0]   LVL_SAT  = (PTR_W + 1)'(127);

    // sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_READ   = 2'd1;
    localparam logic [1:0] ST_SECOND = 2'd2;

    // event memory
    t_entry r_mem [QUEUE_DEPTH];

    logic [1:0]       r_state, n_state;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [PTR_W-1:0] r_wp, n_wp;
    t_entry           r_rd_data;
    logic             r_mounted, r_usb_ready, r_writable;
    t_result          r_out, n_out;
    logic             r_out_valid;
    t_result          r_second, n_second;

    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    t_entry           wr_data;
    logic             rd_en;
    logic             load_out;
    logic             load_second;

    logic             in_hs;
    logic             out_free;
    logic [PTR_W-1:0] wp_inc, rp_inc;
    logic             full;

    // message build
    logic             is_msg;
    t_entry           new_entry;
    logic [15:0]      bend_sat;

    // head service
    t_entry           svc_entry;
    logic             svc_stall;
    logic             svc_usb;
    logic             svc_uart;
    logic             svc_pop;
    logic [1:0]       svc_len;
    logic [7:0]       svc_byte;
    logic [6:0]       svc_level;
    t_result          res_usb, res_uart, res_ack;

    // events held, saturated to the 7-bit level field
    function automatic logic [6:0] level_of(input logic [PTR_W-1:0] w,
                                            input logic [PTR_W-1:0] r);
        logic [PTR_W:0] d;
        if (w >= r) begin
            d = {1'b0, w} - {1'b0, r};
        end else begin
            d = {1'b0, w} + DEPTH_X - {1'b0, r};
        end
        return (d > LVL_SAT) ? LEVEL_MAX : 7'(d);
    endfunction

    function automatic t_result make_ack(input logic acc, input logic [6:0] lvl);
        t_result r;
        r = '0;
        r.kind        = KIND_ACK;
        r.accepted    = acc;
        r.queue_level = lvl;
        r.last        = 1'b1;
        return r;
    endfunction

    assign in_hs    = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE) && out_free;

    assign wp_inc = (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
    assign rp_inc = (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
    assign full   = (wp_inc == r_rp);

    // decode the command into a new event
    always_comb begin
        is_msg    = 1'b1;
        new_entry = '0;
        bend_sat  = (i_in.bend > BEND_MAX) ? BEND_MAX : i_in.bend;
        new_entry.three_bytes = 1'b1;
        new_entry.d1 = i_in.data1[6:0];
        new_entry.d2 = i_in.data2[6:0];
        unique case (i_in.cmd)
            CMD_NOTE_ON: begin
                new_entry.status = STATUS_NOTE_ON | {4'b0, i_in.channel};
            end
            CMD_NOTE_OFF: begin
                new_entry.status = STATUS_NOTE_OFF | {4'b0, i_in.channel};
                new_entry.d2     = '0;
            end
            CMD_CC: begin
                new_entry.status = STATUS_CC | {4'b0, i_in.channel};
            end
            CMD_USB_CC: begin
                new_entry.status   = STATUS_CC | {4'b0, i_in.channel};
                new_entry.usb_only = 1'b1;
            end
            CMD_PROGRAM: begin
                new_entry.status      = STATUS_PROGRAM | {4'b0, i_in.channel};
                new_entry.d2          = '0;
                new_entry.three_bytes = 1'b0;
            end
            CMD_BEND: begin
                new_entry.status = STATUS_BEND | {4'b0, i_in.channel};
                new_entry.d1     = bend_sat[6:0];
                new_entry.d2     = bend_sat[13:7];
            end
            default: begin
                is_msg = 1'b0;
            end
        endcase
    end

    // work on the head entry read from memory
    always_comb begin
        svc_entry = r_rd_data;
        svc_stall = 1'b0;
        svc_usb   = 1'b0;
        svc_uart  = 1'b0;
        svc_pop   = 1'b0;
        svc_len   = r_rd_data.three_bytes ? 2'd3 : 2'd2;
        if (!r_rd_data.usb_done) begin
            if (!r_mounted) begin
                svc_entry.usb_done = 1'b1;
            end else if (r_usb_ready) begin
                svc_usb            = 1'b1;
                svc_entry.usb_done = 1'b1;
            end else begin
                svc_stall = 1'b1;
            end
        end
        if (!svc_stall) begin
            if (r_rd_data.usb_only) begin
                svc_pop = 1'b1;
            end else begin
                if (r_writable && (r_rd_data.pos < svc_len)) begin
                    svc_uart      = 1'b1;
                    svc_entry.pos = r_rd_data.pos + 2'd1;
                end
                if (svc_entry.pos >= svc_len) begin
                    svc_pop = 1'b1;
                end
            end
        end
        case (r_rd_data.pos)
            2'd0:    svc_byte = r_rd_data.status;
            2'd1:    svc_byte = {1'b0, r_rd_data.d1};
            default: svc_byte = {1'b0, r_rd_data.d2};
        endcase
    end

    assign svc_level = level_of(r_wp, svc_pop ? rp_inc : r_rp);

    always_comb begin
        res_usb             = '0;
        res_usb.kind        = KIND_USB;
        res_usb.usb_packet  = {4'b0, r_rd_data.status[7:4], r_rd_data.status,
                               1'b0, r_rd_data.d1, 1'b0, r_rd_data.d2};
        res_usb.queue_level = svc_level;
        res_usb.last        = !svc_uart;
        res_uart             = '0;
        res_uart.kind        = KIND_UART;
        res_uart.uart_byte   = svc_byte;
        res_uart.queue_level = svc_level;
        res_uart.last        = 1'b1;
        res_ack              = make_ack(1'b0, svc_level);
    end

    // sequencer: accept, read, write back and emit
    always_comb begin
        n_state     = r_state;
        n_rp        = r_rp;
        n_wp        = r_wp;
        wr_en       = 1'b0;
        wr_addr     = r_wp;
        wr_data     = new_entry;
        rd_en       = 1'b0;
        load_out    = 1'b0;
        n_out       = r_out;
        load_second = 1'b0;
        n_second    = res_uart;
        unique case (r_state)
            ST_IDLE: begin
                if (in_hs) begin
                    if (is_msg) begin
                        if (!full) begin
                            wr_en = 1'b1;
                            n_wp  = wp_inc;
                        end
                        load_out = 1'b1;
                        n_out    = make_ack(!full, level_of(full ? r_wp : wp_inc, r_rp));
                    end else if (i_in.cmd == CMD_DISCARD) begin
                        n_rp     = r_wp;
                        load_out = 1'b1;
                        n_out    = make_ack(1'b0, level_of(r_wp, r_wp));
                    end else if (r_rp == r_wp) begin
                        // service on an empty queue
                        load_out = 1'b1;
                        n_out    = make_ack(1'b0, level_of(r_wp, r_rp));
                    end else begin
                        rd_en   = 1'b1;
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                if (out_free) begin
                    wr_en    = 1'b1;
                    wr_addr  = r_rp;
                    wr_data  = svc_entry;
                    load_out = 1'b1;
                    if (svc_pop) begin
                        n_rp = rp_inc;
                    end
                    if (svc_usb) begin
                        n_out = res_usb;
                    end else if (svc_uart) begin
                        n_out = res_uart;
                    end else begin
                        n_out = res_ack;
                    end
                    if (svc_usb && svc_uart) begin
                        load_second = 1'b1;
                        n_state     = ST_SECOND;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_SECOND: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_out    = r_second;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // memory port: one write and one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_rp];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rp        <= '0;
            r_wp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rp    <= n_rp;
            r_wp    <= n_wp;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_mounted   <= i_in.usb_mounted;
            r_usb_ready <= i_in.usb_ready;
            r_writable  <= i_in.uart_writable;
        end
        if (load_out) begin
            r_out <= n_out;
        end
        if (load_second) begin
            r_second <= n_second;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_out.kind;
    assign o_out.usb_packet  = r_out.usb_packet;
    assign o_out.uart_byte   = r_out.uart_byte;
    assign o_out.accepted    = r_out.accepted;
    assign o_out.queue_level = r_out.queue_level;
    assign o_out.last        = r_out.last;

endmodule

[rtl/core/mtxq_checker.sv]
// mtxq_checker: port-level assertions for midi_tx_event_queue, with its bind
// depends on mtxq_pkg and midi_tx_event_queue
module mtxq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [2:0]  i_in_cmd,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_out_kind,
    input logic [31:0] i_out_packet,
    input logic [7:0]  i_out_byte,
    input logic        i_out_accepted,
    input logic [6:0]  i_out_level,
    input logic        i_out_last
);
    import mtxq_pkg::*;

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_kind)
            && $stable(i_out_packet) && $stable(i_out_byte) && $stable(i_out_accepted)
            && $stable(i_out_level) && $stable(i_out_last)))
        else $error("result word changed while stalled");

    // reset empties the output
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // discard answers next cycle with an empty queue
    a_discard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_cmd == CMD_DISCARD)
            |=> (i_out_valid && i_out_last && i_out_level == 7'd0))
        else $error("discard not acknowledged with empty queue");

    // a two-word answer is a usb packet then, next cycle, a uart byte
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_last)
            |-> (i_out_kind == KIND_USB) ##1 (i_out_valid && i_out_kind == KIND_UART))
        else $error("bad two-word result sequence");

endmodule

bind midi_tx_event_queue mtxq_checker u_mtxq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_cmd       (i_in.cmd),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_kind     (o_out.kind),
    .i_out_packet   (o_out.usb_packet),
    .i_out_byte     (o_out.uart_byte),
    .i_out_accepted (o_out.accepted),
    .i_out_level    (o_out.queue_level),
    .i_out_last     (o_out.last)
);

[tb/sv/midi_tx_event_queue_tb.sv]
`timescale 1ns / 1ps
// midi_tx_event_queue_tb: self-checking bench for the midi transmit event queue
// depends on mtxq_pkg, the channel interfaces in mtxq_if.sv and midi_tx_event_queue
module midi_tx_event_queue_tb;
    import mtxq_pkg::*;

    localparam int QDEPTH      = 128;
    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD   = 400;     // receiver hold-off, in cycles
    localparam int END_SETTLE  = 20;      // quiet cycles after the last result

    // one command word as offered on the input channel
    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  channel;
        logic [7:0]  data1;
        logic [7:0]  data2;
        logic [15:0] bend;
        logic        mounted;
        logic        usb_rdy;
        logic        writable;
    } t_midi_cmd;

    // one row of the directed table; fixed_res holds a hand-typed result word
    typedef struct {
        t_midi_cmd word;
        bit        typed;
        t_result   fixed_res;
    } t_stim_row;

    // one queued midi event as the bench tracks it
    typedef struct {
        logic [7:0] status;
        logic [6:0] d1;
        logic [6:0] d2;
        logic [1:0] len;
        bit         usb_only;
        bit         usb_done;
        logic [1:0] pos;
    } t_midi_ev;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_FREE,
        RX_RANDOM,
        RX_PATTERN
    } t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mtxq_in_if  in_ch ();
    mtxq_out_if out_ch ();

    midi_tx_event_queue #(
        .QUEUE_DEPTH (QDEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // bench-side image of the queue: events, pointers, predicted words
    // ------------------------------------------------------------------
    t_midi_ev queued_ev [QDEPTH];
    int       rd_ptr = 0;
    int       wr_ptr = 0;
    t_result  predicted_words [$];

    t_stim_row stim_rows [$];

    int error_count = 0;
    int words_sent  = 0;
    int words_seen  = 0;
    int cycle_count = 0;
    int burst_left  = 0;

    // events held, clipped to the width of queue_level
    function automatic logic [6:0] held_events();
        int lv;
        lv = (wr_ptr + QDEPTH - rd_ptr) % QDEPTH;
        return (lv > LEVEL_MAX) ? LEVEL_MAX : lv[6:0];
    endfunction

    // append at the tail; a full queue (one slot kept free) drops the event
    function automatic bit enqueue_event(input logic [7:0] st, input logic [6:0] d1,
                                         input logic [6:0] d2, input logic [1:0] len,
                                         input bit usb_only);
        int nxt;
        nxt = (wr_ptr + 1) % QDEPTH;
        if (nxt == rd_ptr) begin
            return 1'b0;
        end
        queued_ev[wr_ptr].status   = st;
        queued_ev[wr_ptr].d1       = d1;
        queued_ev[wr_ptr].d2       = d2;
        queued_ev[wr_ptr].len      = len;
        queued_ev[wr_ptr].usb_only = usb_only;
        queued_ev[wr_ptr].usb_done = 1'b0;
        queued_ev[wr_ptr].pos      = 2'd0;
        wr_ptr = nxt;
        return 1'b1;
    endfunction

    function automatic t_result ack_word(input bit acc, input logic [6:0] lvl);
        t_result r;
        r             = '0;
        r.kind        = KIND_ACK;
        r.accepted    = acc;
        r.queue_level = lvl;
        r.last        = 1'b1;
        return r;
    endfunction

    // advance the queue image by one accepted word and file the words it causes;
    // a typed row files its hand-written word instead, the image still advances
    task automatic predict_queue_step(input t_midi_cmd w, input bit typed,
                                      input t_result fixed_res);
        t_result    r [2];
        int         n;
        bit         acc;
        bit         stalled;
        logic [15:0] bsat;
        logic [7:0]  st;
        n    = 0;
        acc  = 1'b0;
        r[0] = '0;
        r[1] = '0;
        st   = {4'd0, w.channel};
        bsat = (w.bend > BEND_MAX) ? BEND_MAX : w.bend;
        case (w.cmd)
            CMD_NOTE_ON: begin
                acc = enqueue_event(STATUS_NOTE_ON | st, w.data1[6:0], w.data2[6:0], 2'd3, 1'b0);
            end
            CMD_NOTE_OFF: begin
                acc = enqueue_event(STATUS_NOTE_OFF | st, w.data1[6:0], 7'd0, 2'd3, 1'b0);
            end
            CMD_CC: begin
                acc = enqueue_event(STATUS_CC | st, w.data1[6:0], w.data2[6:0], 2'd3, 1'b0);
            end
            CMD_USB_CC: begin
                acc = enqueue_event(STATUS_CC | st, w.data1[6:0], w.data2[6:0], 2'd3, 1'b1);
            end
            CMD_PROGRAM: begin
                acc = enqueue_event(STATUS_PROGRAM | st, w.data1[6:0], 7'd0, 2'd2, 1'b0);
            end
            CMD_BEND: begin
                // low 7 bits first, then the next 7
                acc = enqueue_event(STATUS_BEND | st, bsat[6:0], bsat[13:7], 2'd3, 1'b0);
            end
            CMD_DISCARD: begin
                rd_ptr = wr_ptr;
            end
            default: begin
                // service: only the head event is touched
                if (rd_ptr != wr_ptr) begin
                    stalled = 1'b0;
                    if (!queued_ev[rd_ptr].usb_done) begin
                        if (!w.mounted) begin
                            // no usb link: the usb leg counts as done
                            queued_ev[rd_ptr].usb_done = 1'b1;
                        end else if (w.usb_rdy) begin
                            r[n].kind       = KIND_USB;
                            r[n].usb_packet = {4'd0, queued_ev[rd_ptr].status[7:4],
                                               queued_ev[rd_ptr].status,
                                               1'b0, queued_ev[rd_ptr].d1,
                                               1'b0, queued_ev[rd_ptr].d2};
                            n++;
                            queued_ev[rd_ptr].usb_done = 1'b1;
                        end else begin
                            stalled = 1'b1;
                        end
                    end
                    if (!stalled) begin
                        if (queued_ev[rd_ptr].usb_only) begin
                            rd_ptr = (rd_ptr + 1) % QDEPTH;
                        end else begin
                            if (w.writable && queued_ev[rd_ptr].pos < queued_ev[rd_ptr].len) begin
                                r[n].kind = KIND_UART;
                                case (queued_ev[rd_ptr].pos)
                                    2'd0:    r[n].uart_byte = queued_ev[rd_ptr].status;
                                    2'd1:    r[n].uart_byte = {1'b0, queued_ev[rd_ptr].d1};
                                    default: r[n].uart_byte = {1'b0, queued_ev[rd_ptr].d2};
                                endcase
                                n++;
                                queued_ev[rd_ptr].pos = queued_ev[rd_ptr].pos + 2'd1;
                            end
                            if (queued_ev[rd_ptr].pos >= queued_ev[rd_ptr].len) begin
                                rd_ptr = (rd_ptr + 1) % QDEPTH;
                            end
                        end
                    end
                end
            end
        endcase
        if (n == 0) begin
            r[0].kind     = KIND_ACK;
            r[0].accepted = acc;
            n             = 1;
        end
        for (int k = 0; k < n; k++) begin
            r[k].queue_level = held_events();
        end
        r[n-1].last = 1'b1;
        if (typed) begin
            predicted_words.push_back(fixed_res);
        end else begin
            for (int k = 0; k < n; k++) begin
                predicted_words.push_back(r[k]);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_midi_cmd rand_word(input logic [2:0] op);
        t_midi_cmd w;
        w.cmd     = op;
        w.channel = 4'($urandom_range(0, 15));
        w.data1   = 8'($urandom_range(0, 255));
        w.data2   = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0:       w.bend = 16'($urandom_range(16384, 65535));   // saturates
            1:       w.bend = $urandom_range(0, 1) ? BEND_MAX : 16'd0;
            default: w.bend = 16'($urandom_range(0, 16383));
        endcase
        w.mounted  = ($urandom_range(0, 9) != 0);
        w.usb_rdy  = ($urandom_range(0, 4) != 0);
        w.writable = ($urandom_range(0, 3) != 0);
        return w;
    endfunction

    function automatic logic [2:0] rand_msg_cmd();
        return 3'($urandom_range(CMD_NOTE_ON, CMD_BEND));
    endfunction

    task automatic add_row(input logic [2:0] op, input logic [3:0] ch, input logic [7:0] d1,
                           input logic [7:0] d2, input logic [15:0] bnd, input logic mnt,
                           input logic rdy, input logic wr, input bit typed,
                           input t_result res);
        t_stim_row row;
        row.word      = {op, ch, d1, d2, bnd, mnt, rdy, wr};
        row.typed     = typed;
        row.fixed_res = res;
        stim_rows.push_back(row);
    endtask

    // offer one word: the sender runs in bursts with random gaps between them;
    // called and returning at a rising edge
    task automatic offer_word(input t_midi_cmd w, input bit typed, input t_result res);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 30);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid         <= 1'b1;
        in_ch.cmd           <= w.cmd;
        in_ch.channel       <= w.channel;
        in_ch.data1         <= w.data1;
        in_ch.data2         <= w.data2;
        in_ch.bend          <= w.bend;
        in_ch.usb_mounted   <= w.mounted;
        in_ch.usb_ready     <= w.usb_rdy;
        in_ch.uart_writable <= w.writable;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_queue_step(w, typed, res);
        words_sent++;
    endtask

    // sender goes quiet until every predicted word has come out
    task automatic pause_until_drained();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (predicted_words.size() != 0);
    endtask

    // service words until the queue image is empty
    task automatic drain_queue();
        while (held_events() != 0) begin
            offer_word(rand_word(CMD_SERVICE), 1'b0, '0);
        end
    endtask

    // mostly services, a good share of messages, the odd discard
    function automatic t_midi_cmd mixed_word();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) begin
            return rand_word(rand_msg_cmd());
        end else if (p < 97) begin
            return rand_word(CMD_SERVICE);
        end
        return rand_word(CMD_DISCARD);
    endfunction

    // ------------------------------------------------------------------
    // receiver: own stall pattern, plus one long hold-off on request
    // ------------------------------------------------------------------
    logic     hold_req;
    bit       hold_done = 1'b0;
    int       hold_left = 0;
    t_rx_mode rx_mode   = RX_FREE;
    int       mode_left = 0;
    logic [2:0] pat_cnt = 3'd0;

    always @(posedge i_clk) begin
        pat_cnt <= pat_cnt + 3'd1;
        if (mode_left == 0) begin
            rx_mode   <= t_rx_mode'($urandom_range(RX_FREE, RX_PATTERN));
            mode_left <= $urandom_range(40, 300);
        end else begin
            mode_left <= mode_left - 1;
        end
        if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            // long hold-off: the output register stays full and the input backs up
            hold_done    <= 1'b1;
            hold_left    <= LONG_HOLD;
            out_ch.ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_FREE:    out_ch.ready <= 1'b1;
                RX_RANDOM:  out_ch.ready <= 1'($urandom_range(0, 1));
                default:    out_ch.ready <= (pat_cnt != 3'd5) && (pat_cnt != 3'd6);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("ERROR word %0d: %0s", words_seen, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%0s got 0x%0h expected 0x%0h", name, got, want));
        end
    endtask

    t_result want_word;

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (predicted_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word, kind %0d level %0d",
                                          out_ch.kind, out_ch.queue_level));
            end else begin
                want_word = predicted_words.pop_front();
                check_field("kind", 32'(out_ch.kind), 32'(want_word.kind));
                check_field("usb_packet", out_ch.usb_packet, want_word.usb_packet);
                check_field("uart_byte", 32'(out_ch.uart_byte), 32'(want_word.uart_byte));
                check_field("accepted", 32'(out_ch.accepted), 32'(want_word.accepted));
                check_field("queue_level", 32'(out_ch.queue_level),
                            32'(want_word.queue_level));
                check_field("last", 32'(out_ch.last), 32'(want_word.last));
            end
            words_seen++;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        i_rst_n             <= 1'b0;
        hold_req            <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.cmd           <= CMD_SERVICE;
        in_ch.channel       <= 4'd0;
        in_ch.data1         <= 8'd0;
        in_ch.data2         <= 8'd0;
        in_ch.bend          <= 16'd0;
        in_ch.usb_mounted   <= 1'b0;
        in_ch.usb_ready     <= 1'b0;
        in_ch.uart_writable <= 1'b0;

        // directed table: op, channel, data1, data2, bend, mounted, usb ready,
        // uart writable, then a hand-typed word where it is obvious
        // service and discard straight after reset
        add_row(CMD_SERVICE,  4'd0,  8'h00, 8'h00, 16'h0000, 1, 1, 1, 1, ack_word(0, 0));
        add_row(CMD_DISCARD,  4'd0,  8'h00, 8'h00, 16'h0000, 0, 0, 0, 1, ack_word(0, 0));
        // note on with every data bit set, masked to 7 bits
        add_row(CMD_NOTE_ON,  4'd15, 8'hff, 8'hff, 16'hffff, 0, 0, 0, 1, ack_word(1, 1));
        // usb packet and status byte in one step, then the two data bytes
        add_row(CMD_SERVICE,  4'd0,  8'h00, 8'h00, 16'h0000, 1, 1, 1, 0, '0);
        add_row(CMD_SERVICE,  4'd0,  8'h00, 8'h00, 16'h0000, 0, 0, 1, 0, '0);
        add_row(CMD_SERVICE,  4'd0,  8'h00, 8'h00, 16'h0000, 1, 0, 1, 0, '0);
        // note off forces velocity to zero
        add_row(CMD_NOTE_OFF, 4'd0,  8'h80, 8'hff, 16'h0000, 0, 0, 0, 1, ack_word(1, 1));
        // usb sink not ready: head stalls, uart untouched
        add_row(CMD_SERVICE,  4'd0,  8'h00, 8'h00, 16'h0000, 1, 0, 1, 1, ack_word(0, 1));
        // usb packet alone while the uart is busy
        add_row(CMD_SERVICE,  4'd0,  8'h00, 8'h00, 16'h0000, 1, 1, 0, 0, '0);
        add_row(CMD_SERVICE,  4'd0,  8'h00, 8'h00, 16'h0000, 0, 0, 1, 0, '0);
        add_row(CMD_SERVICE,  4'd0,  8'h00, 8'h00, 16'h0000, 0, 0, 1, 0, '0);
        add_row(CMD_SERVICE,  4'd0,  8'h00, 8'h00, 16'h0000, 0, 0, 1, 0, '0);
        // usb-only cc with no usb link: popped with nothing sent
        add_row(CMD_USB_CC,   4'd5,  8'h07, 8'hc0, 16'h0000, 0, 0, 0, 1, ack_word(1, 1));
        add_row(CMD_SERVICE,  4'd0,  8'h00, 8'h00, 16'h0000, 0, 1, 1, 1, ack_word(0, 0));
        // program change is two uart bytes
        add_row(CMD_PROGRAM,  4'd3,  8'haa, 8'h33, 16'h0000, 0, 0, 0, 1, ack_word(1, 1));
        add_row(CMD_SERVICE,  4'd0,  8'h00, 8'h00, 16'h0000, 1, 1, 1, 0, '0);
        add_row(CMD_SERVICE,  4'd0,  8'h00, 8'h00, 16'h0000, 1, 1, 1, 0, '0);
        // cc, then bend at zero, at full scale and past it
        add_row(CMD_CC,       4'd9,  8'h7f, 8'h80, 16'h0000, 0, 0, 0, 1, ack_word(1, 1));
        add_row(CMD_BEND,     4'd0,  8'h00, 8'h00, 16'h0000, 0, 0, 0, 1, ack_word(1, 2));
        add_row(CMD_BEND,     4'd15, 8'h00, 8'h00, 16'h3fff, 0, 0, 0, 1, ack_word(1, 3));
        add_row(CMD_BEND,     4'd1,  8'hff, 8'hff, 16'hffff, 1, 1, 1, 1, ack_word(1, 4));
        // discard drops everything queued
        add_row(CMD_DISCARD,  4'd0,  8'h00, 8'h00, 16'h0000, 1, 1, 1, 1, ack_word(0, 0));
        // usb-only cc over a mounted link: one packet, no uart
        add_row(CMD_USB_CC,   4'd15, 8'hff, 8'hff, 16'h0000, 1, 1, 1, 1, ack_word(1, 1));
        add_row(CMD_SERVICE,  4'd0,  8'h00, 8'h00, 16'h0000, 1, 1, 0, 0, '0);
        add_row(CMD_SERVICE,  4'd0,  8'h00, 8'h00, 16'h0000, 1, 1, 1, 1, ack_word(0, 0));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[i]) begin
            offer_word(stim_rows[i].word, stim_rows[i].typed, stim_rows[i].fixed_res);
        end
        pause_until_drained();

        // fill well past capacity behind a long receiver hold-off; the tail
        // of the burst finds the queue full and is dropped
        hold_req <= 1'b1;
        repeat (140) offer_word(rand_word(rand_msg_cmd()), 1'b0, '0);
        pause_until_drained();
        drain_queue();

        // random part: mostly short mixed runs, now and then a deep fill and drain
        while (words_sent < 1080) begin
            case ($urandom_range(0, 19))
                0: begin
                    repeat ($urandom_range(20, 80)) begin
                        offer_word(rand_word(rand_msg_cmd()), 1'b0, '0);
                    end
                    drain_queue();
                end
                1: offer_word(rand_word(CMD_DISCARD), 1'b0, '0);
                2: pause_until_drained();
                default: begin
                    repeat ($urandom_range(4, 40)) offer_word(mixed_word(), 1'b0, '0);
                end
            endcase
        end

        pause_until_drained();
        repeat (END_SETTLE) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/mtxq_pkg.sv
rtl/core/mtxq_if.sv
rtl/core/midi_tx_event_queue.sv
rtl/core/mtxq_checker.sv
tb/sv/midi_tx_event_queue_tb.sv
